### design/tpmi_pkg.sv
// ----------------------------------------------------------------------------
// tpmi_pkg
// Shared constants and types of the third-pel motion interpolator.
// ----------------------------------------------------------------------------
package tpmi_pkg;

  localparam int MAX_WIDTH = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W    = 5;

  localparam logic [2:0] REG_FRAC_X       = 3'd0;
  localparam logic [2:0] REG_FRAC_Y       = 3'd1;
  localparam logic [2:0] REG_AVG_MODE     = 3'd2;
  localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd3;
  localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd4;

  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  localparam logic [9:0]  LIN_MUL   = 10'd683;
  localparam int          LIN_SHIFT = 11;
  localparam logic [11:0] BIL_MUL   = 12'd2731;
  localparam int          BIL_SHIFT = 15;
  localparam logic [11:0] BIL_ROUND = 12'd6;

  typedef struct packed {
    logic [1:0] frac_x;
    logic [1:0] frac_y;
    logic       avg_mode;
    logic [4:0] block_width;
    logic [4:0] block_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] dst_old;
    logic [1:0] fx;
    logic [1:0] fy;
    logic       avg;
    logic       last;
  } nbhd_t;

endpackage

### design/thirdpel_motion_interpolator.sv
// ----------------------------------------------------------------------------
// thirdpel_motion_interpolator
// Third-pel motion-compensation interpolator for 8-bit pixels.
//
//   channel  handshake                 payload
//   pixel    pixel_valid/pixel_stall   src_pixel, dst_old
//   pred     pred_valid/pred_stall     pred_pixel, block_last
//   config   APB write/read            frac_x, frac_y, avg_mode, block_width,
//                                      block_height at 0x00..0x10
//
// One pixel transfer per cycle while pixel_stall is low; the result of a
// position is registered in the neighbourhood register and then in the result
// register. Window row 0 and column 0 give no result.
// Synchronous reset clears the line store, counters and both valid flags.
// A stall on pred holds the result and backs up into pixel_stall only once
// the neighbourhood register is also full.
// ----------------------------------------------------------------------------
module thirdpel_motion_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic [7:0]                  src_pixel,
  input  logic [7:0]                  dst_old,
  output logic                        pred_valid,
  input  logic                        pred_stall,
  output logic [7:0]                  pred_pixel,
  output logic                        block_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpmi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tpmi_pkg::*;

  cfg_t  cfg;
  nbhd_t nb;
  logic  nb_valid;
  logic  nb_take;

  tpmi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpmi_window u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .src_pixel   (src_pixel),
    .dst_old     (dst_old),
    .nb          (nb),
    .nb_valid    (nb_valid),
    .nb_take     (nb_take)
  );

  tpmi_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .nb         (nb),
    .nb_valid   (nb_valid),
    .nb_take    (nb_take),
    .pred_valid (pred_valid),
    .pred_stall (pred_stall),
    .pred_pixel (pred_pixel),
    .block_last (block_last)
  );

endmodule

### design/tpmi_regs.sv
// ----------------------------------------------------------------------------
// tpmi_regs
// APB-style configuration registers: phase, average mode and block size.
// ----------------------------------------------------------------------------
module tpmi_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tpmi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tpmi_pkg::cfg_t            cfg
);
  import tpmi_pkg::*;

  logic [2:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frac_x       <= 2'd0;
      cfg.frac_y       <= 2'd0;
      cfg.avg_mode     <= 1'b0;
      cfg.block_width  <= 5'd16;
      cfg.block_height <= 5'd16;
    end else if (wr) begin
      case (index)
        REG_FRAC_X:       cfg.frac_x       <= pwdata[1:0];
        REG_FRAC_Y:       cfg.frac_y       <= pwdata[1:0];
        REG_AVG_MODE:     cfg.avg_mode     <= pwdata[0];
        REG_BLOCK_WIDTH:  cfg.block_width  <= pwdata[4:0];
        REG_BLOCK_HEIGHT: cfg.block_height <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_FRAC_X:       prdata = {30'd0, cfg.frac_x};
      REG_FRAC_Y:       prdata = {30'd0, cfg.frac_y};
      REG_AVG_MODE:     prdata = {31'd0, cfg.avg_mode};
      REG_BLOCK_WIDTH:  prdata = {27'd0, cfg.block_width};
      REG_BLOCK_HEIGHT: prdata = {27'd0, cfg.block_height};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### design/tpmi_window.sv
// ----------------------------------------------------------------------------
// tpmi_window
// Line store, neighbour registers and window position counters; registers
// the 2x2 neighbourhood of each output position.
// ----------------------------------------------------------------------------
module tpmi_window (
  input  logic           clk,
  input  logic           rst,
  input  tpmi_pkg::cfg_t cfg,
  input  logic           pixel_valid,
  output logic           pixel_stall,
  input  logic [7:0]     src_pixel,
  input  logic [7:0]     dst_old,
  output tpmi_pkg::nbhd_t nb,
  output logic           nb_valid,
  input  logic           nb_take
);
  import tpmi_pkg::*;

  logic [7:0]       previous_row [MAX_WIDTH+1];
  logic [7:0]       upper_left;
  logic [7:0]       left_pixel;
  logic [COL_W-1:0] column_count;
  logic [4:0]       row_count;

  logic             accept;
  logic             produce;
  logic             row_end;
  logic             last;
  logic [7:0]       above;
  logic [COL_W-1:0] w_eff;
  logic [4:0]       h_eff;
  logic [1:0]       fx;
  logic [1:0]       fy;

  assign pixel_stall = nb_valid && !nb_take;
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    if (cfg.block_width == 5'd0) begin
      w_eff = COL_W'(1);
    end else if (32'(cfg.block_width) > 32'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(cfg.block_width);
    end
    h_eff = (cfg.block_height == 5'd0) ? 5'd1 : cfg.block_height;
    fx    = (cfg.frac_x > PHASE_2) ? PHASE_2 : cfg.frac_x;
    fy    = (cfg.frac_y > PHASE_2) ? PHASE_2 : cfg.frac_y;
  end

  assign above   = previous_row[column_count];
  assign produce = (row_count != 5'd0) && (column_count != '0);
  assign row_end = column_count >= w_eff;
  assign last    = (row_count >= h_eff) && row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_WIDTH; i++) begin
        previous_row[i] <= 8'd0;
      end
      upper_left   <= 8'd0;
      left_pixel   <= 8'd0;
      column_count <= '0;
      row_count    <= 5'd0;
      nb_valid     <= 1'b0;
    end else begin
      if (accept) begin
        upper_left                 <= above;
        previous_row[column_count] <= src_pixel;
        left_pixel                 <= src_pixel;
        if (row_end) begin
          column_count <= '0;
          row_count    <= (row_count >= h_eff) ? 5'd0 : row_count + 5'd1;
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
      if (accept && produce) begin
        nb_valid <= 1'b1;
      end else if (nb_take) begin
        nb_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      nb.a       <= upper_left;
      nb.b       <= above;
      nb.c       <= left_pixel;
      nb.d       <= src_pixel;
      nb.dst_old <= dst_old;
      nb.fx      <= fx;
      nb.fy      <= fy;
      nb.avg     <= cfg.avg_mode;
      nb.last    <= last;
    end
  end

endmodule

### design/tpmi_filter.sv
// ----------------------------------------------------------------------------
// tpmi_filter
// Third-pel weighting, optional rounding average and the result register.
// ----------------------------------------------------------------------------
module tpmi_filter (
  input  logic            clk,
  input  logic            rst,
  input  tpmi_pkg::nbhd_t nb,
  input  logic            nb_valid,
  output logic            nb_take,
  output logic            pred_valid,
  input  logic            pred_stall,
  output logic [7:0]      pred_pixel,
  output logic            block_last
);
  import tpmi_pkg::*;

  logic [7:0]  heavy;
  logic [7:0]  light;
  logic [9:0]  lin_sum;
  logic [19:0] lin_prod;
  logic [2:0]  wa, wb, wc, wd;
  logic [11:0] bil_sum;
  logic [23:0] bil_prod;
  logic [7:0]  pred;
  logic [8:0]  avg_sum;
  logic [7:0]  result;

  always_comb begin
    if (nb.fy == PHASE_0) begin
      heavy = (nb.fx == PHASE_1) ? nb.a : nb.b;
      light = (nb.fx == PHASE_1) ? nb.b : nb.a;
    end else begin
      heavy = (nb.fy == PHASE_1) ? nb.a : nb.c;
      light = (nb.fy == PHASE_1) ? nb.c : nb.a;
    end
  end

  assign lin_sum  = {1'b0, heavy, 1'b0} + 10'(light) + 10'd1;
  assign lin_prod = 20'(lin_sum) * 20'(LIN_MUL);

  always_comb begin
    case ({nb.fx, nb.fy})
      {PHASE_1, PHASE_1}: begin wa = 3'd4; wb = 3'd3; wc = 3'd3; wd = 3'd2; end
      {PHASE_2, PHASE_1}: begin wa = 3'd3; wb = 3'd4; wc = 3'd2; wd = 3'd3; end
      {PHASE_1, PHASE_2}: begin wa = 3'd3; wb = 3'd2; wc = 3'd4; wd = 3'd3; end
      default:            begin wa = 3'd2; wb = 3'd3; wc = 3'd3; wd = 3'd4; end
    endcase
  end

  assign bil_sum  = 12'(wa) * 12'(nb.a) + 12'(wb) * 12'(nb.b)
                  + 12'(wc) * 12'(nb.c) + 12'(wd) * 12'(nb.d) + BIL_ROUND;
  assign bil_prod = 24'(bil_sum) * 24'(BIL_MUL);

  always_comb begin
    if (nb.fx == PHASE_0 && nb.fy == PHASE_0) begin
      pred = nb.a;
    end else if (nb.fx == PHASE_0 || nb.fy == PHASE_0) begin
      pred = lin_prod[LIN_SHIFT+7:LIN_SHIFT];
    end else begin
      pred = bil_prod[BIL_SHIFT+7:BIL_SHIFT];
    end
  end

  assign avg_sum = 9'(nb.dst_old) + 9'(pred) + 9'd1;
  assign result  = nb.avg ? avg_sum[8:1] : pred;

  assign nb_take = !pred_valid || !pred_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_valid <= 1'b0;
    end else if (nb_take) begin
      pred_valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (nb_take && nb_valid) begin
      pred_pixel <= result;
      block_last <= nb.last;
    end
  end

endmodule

### design/tpmi_checker.sv
// ----------------------------------------------------------------------------
// tpmi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tpmi_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_valid,
  input logic       pixel_stall,
  input logic       pred_valid,
  input logic       pred_stall,
  input logic [7:0] pred_pixel,
  input logic       block_last
);

  a_pred_hold: assert property (@(posedge clk) disable iff (rst)
    pred_valid && pred_stall |=> pred_valid && $stable(pred_pixel) && $stable(block_last))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> pred_valid && pred_stall)
    else $error("pixel stall without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(pred_valid) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("result without a pixel transfer two cycles earlier");

endmodule

bind thirdpel_motion_interpolator tpmi_checker u_checker (.*);
